FILE: rtl/sfr_pkg.sv
// Shared types and constants for the streaming find-and-replace block.
// Used by sfr_ctrl, sfr_datapath and stream_find_replace; no dependencies.
`default_nettype none

package sfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_REPLACE = 8;
  localparam int LEN_W       = 4;
  localparam int IDX_W       = 3;
  localparam logic [7:0] NEWLINE = 8'd10;

  localparam logic [1:0] REG_PATTERN     = 2'd0;
  localparam logic [1:0] REG_PATTERN_LEN = 2'd1;
  localparam logic [1:0] REG_REPLACE     = 2'd2;
  localparam logic [1:0] REG_REPLACE_LEN = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_DROP,
    S_REPL,
    S_FLUSH,
    S_EMITC,
    S_TAIL,
    S_LFLUSH,
    S_NL,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_APPEND,
    OP_DROP,
    OP_REPL,
    OP_EMIT_C,
    OP_EMIT_NL,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic clr_fill;
  } cmd_t;

  typedef struct packed {
    logic pass;       // pattern length zero or byte is newline
    logic is_nl;
    logic last;
    logic fill_zero;
    logic prefix_ok;
    logic fill_eq_plen;
    logic rlen_zero;
    logic repl_last;
    logic emit_ok;
    logic fin_ok;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/sfr_datapath.sv
// Datapath: config registers, match window, replacement counter and output staging.
// Depends on sfr_pkg; driven by commands from sfr_ctrl.
`default_nettype none

module sfr_datapath (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_addr,
  input  wire logic [63:0]    cfg_wdata,
  input  wire logic [7:0]     in_tdata,
  input  wire logic           in_tlast,
  input  wire sfr_pkg::cmd_t  cmd,
  output sfr_pkg::status_t    stat,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);

  logic [63:0] pat_r;
  logic [63:0] rep_r;
  logic [sfr_pkg::LEN_W-1:0] plen_r;
  logic [sfr_pkg::LEN_W-1:0] rlen_r;
  logic [sfr_pkg::LEN_W-1:0] plen_sat;
  logic [sfr_pkg::LEN_W-1:0] rlen_sat;

  logic [7:0] win_r [sfr_pkg::MAX_PATTERN];
  logic [sfr_pkg::LEN_W-1:0] fill_r;
  logic [sfr_pkg::IDX_W-1:0] rep_idx_r;
  logic [7:0] c_r;
  logic       last_r;

  logic [7:0] pend_byte_r;
  logic       pend_v_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_valid_r;

  logic       emit;
  logic [7:0] emit_byte;
  logic       load_out;
  logic       prefix_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      rep_r  <= '0;
      plen_r <= '0;
      rlen_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sfr_pkg::REG_PATTERN:     pat_r  <= cfg_wdata;
        sfr_pkg::REG_PATTERN_LEN: plen_r <= cfg_wdata[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_REPLACE:     rep_r  <= cfg_wdata;
        sfr_pkg::REG_REPLACE_LEN: rlen_r <= cfg_wdata[sfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign plen_sat = (plen_r > sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN))
                    ? sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN) : plen_r;
  assign rlen_sat = (rlen_r > sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACE))
                    ? sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACE) : rlen_r;

  // window is a prefix of the pattern: fits and agrees byte for byte
  always_comb begin
    prefix_ok = (fill_r <= plen_sat);
    for (int i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin
      if ((sfr_pkg::LEN_W'(i) < fill_r) && (win_r[i] != pat_r[8*i +: 8]))
        prefix_ok = 1'b0;
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.op == sfr_pkg::OP_LATCH) begin
      c_r    <= in_tdata;
      last_r <= in_tlast;
    end
  end

  // window payload: append at the fill point, drop shifts toward the front
  always_ff @(posedge clk) begin
    if (cmd.op == sfr_pkg::OP_APPEND) begin
      win_r[fill_r[sfr_pkg::IDX_W-1:0]] <= c_r;
    end else if (cmd.op == sfr_pkg::OP_DROP) begin
      for (int i = 0; i < sfr_pkg::MAX_PATTERN - 1; i++)
        win_r[i] <= win_r[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.clr_fill) begin
      fill_r <= '0;
    end else if (cmd.op == sfr_pkg::OP_APPEND) begin
      fill_r <= fill_r + 1'b1;
    end else if (cmd.op == sfr_pkg::OP_DROP) begin
      fill_r <= fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_idx_r <= '0;
    end else if (cmd.op == sfr_pkg::OP_APPEND) begin
      rep_idx_r <= '0;
    end else if (cmd.op == sfr_pkg::OP_REPL) begin
      rep_idx_r <= rep_idx_r + 1'b1;
    end
  end

  always_comb begin
    emit = 1'b1;
    case (cmd.op)
      sfr_pkg::OP_DROP:    emit_byte = win_r[0];
      sfr_pkg::OP_REPL:    emit_byte = rep_r[{rep_idx_r, 3'b000} +: 8];
      sfr_pkg::OP_EMIT_C:  emit_byte = c_r;
      sfr_pkg::OP_EMIT_NL: emit_byte = sfr_pkg::NEWLINE;
      default: begin
        emit      = 1'b0;
        emit_byte = c_r;
      end
    endcase
  end

  // One byte waits in the pending stage so its last flag is known when the
  // next byte arrives or the item finishes.
  assign load_out = pend_v_r && (emit || (cmd.op == sfr_pkg::OP_FINISH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        pend_v_r <= 1'b1;
      end else if (cmd.op == sfr_pkg::OP_FINISH) begin
        pend_v_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit)
      pend_byte_r <= emit_byte;
    if (load_out) begin
      out_byte_r <= pend_byte_r;
      out_last_r <= !emit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  assign stat.pass         = (plen_sat == '0) || (c_r == sfr_pkg::NEWLINE);
  assign stat.is_nl        = (c_r == sfr_pkg::NEWLINE);
  assign stat.last         = last_r;
  assign stat.fill_zero    = (fill_r == '0);
  assign stat.prefix_ok    = prefix_ok;
  assign stat.fill_eq_plen = (fill_r == plen_sat);
  assign stat.rlen_zero    = (rlen_sat == '0);
  assign stat.repl_last    = ({1'b0, rep_idx_r} + 1'b1) == rlen_sat;
  assign stat.emit_ok      = !pend_v_r || !out_valid_r || out_tready;
  assign stat.fin_ok       = stat.emit_ok;

endmodule

`default_nettype wire

FILE: rtl/sfr_ctrl.sv
// Controller state machine: sequences window drops, replacement and flushes.
// Depends on sfr_pkg; issues commands to sfr_datapath.
`default_nettype none

module sfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire sfr_pkg::status_t  stat,
  output sfr_pkg::cmd_t          cmd
);

  sfr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = sfr_pkg::OP_NONE;
    cmd.clr_fill = 1'b0;
    in_tready    = 1'b0;
    unique case (state_r)
      sfr_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = sfr_pkg::OP_LATCH;
          state_nxt = sfr_pkg::S_START;
        end
      end
      sfr_pkg::S_START: begin
        if (stat.pass) begin
          state_nxt = sfr_pkg::S_FLUSH;
        end else begin
          cmd.op    = sfr_pkg::OP_APPEND;
          state_nxt = sfr_pkg::S_DROP;
        end
      end
      sfr_pkg::S_DROP: begin
        if (!stat.fill_zero && !stat.prefix_ok) begin
          if (stat.emit_ok) cmd.op = sfr_pkg::OP_DROP;
        end else if (stat.fill_eq_plen) begin
          if (stat.rlen_zero) begin
            cmd.clr_fill = 1'b1;
            state_nxt    = sfr_pkg::S_TAIL;
          end else begin
            state_nxt = sfr_pkg::S_REPL;
          end
        end else begin
          state_nxt = sfr_pkg::S_TAIL;
        end
      end
      sfr_pkg::S_REPL: begin
        if (stat.emit_ok) begin
          cmd.op = sfr_pkg::OP_REPL;
          if (stat.repl_last) begin
            cmd.clr_fill = 1'b1;
            state_nxt    = sfr_pkg::S_TAIL;
          end
        end
      end
      sfr_pkg::S_FLUSH: begin
        if (!stat.fill_zero) begin
          if (stat.emit_ok) cmd.op = sfr_pkg::OP_DROP;
        end else begin
          state_nxt = sfr_pkg::S_EMITC;
        end
      end
      sfr_pkg::S_EMITC: begin
        if (stat.emit_ok) begin
          cmd.op    = sfr_pkg::OP_EMIT_C;
          state_nxt = sfr_pkg::S_TAIL;
        end
      end
      sfr_pkg::S_TAIL: begin
        state_nxt = stat.last ? sfr_pkg::S_LFLUSH : sfr_pkg::S_FIN;
      end
      sfr_pkg::S_LFLUSH: begin
        if (!stat.fill_zero) begin
          if (stat.emit_ok) cmd.op = sfr_pkg::OP_DROP;
        end else begin
          state_nxt = stat.is_nl ? sfr_pkg::S_FIN : sfr_pkg::S_NL;
        end
      end
      sfr_pkg::S_NL: begin
        if (stat.emit_ok) begin
          cmd.op    = sfr_pkg::OP_EMIT_NL;
          state_nxt = sfr_pkg::S_FIN;
        end
      end
      sfr_pkg::S_FIN: begin
        if (stat.fin_ok) begin
          cmd.op    = sfr_pkg::OP_FINISH;
          state_nxt = sfr_pkg::S_IDLE;
        end
      end
      default: state_nxt = sfr_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/stream_find_replace.sv
// Streaming find-and-replace: top level joining sfr_ctrl and sfr_datapath.
// Depends on sfr_pkg, sfr_ctrl, sfr_datapath.
//
// Text bytes enter one item at a time; every leftmost, non-overlapping match of
// the pattern (up to 8 bytes, never across a newline) is replaced by the
// replacement (up to 8 bytes). in_tlast marks the end of a text: the window is
// flushed and a newline added if the final byte was not one. out_tlast marks
// the last output byte caused by an input item (an item may cause none).
// One item is handled at a time by the controller, which emits each output
// byte it causes (window drops, replacement bytes, flush, newline) in turn
// through the single emit path and waits on out_tready while the output is
// stalled. Output bytes are delayed one stage so their last flag is known.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module stream_find_replace (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast   // last_of_run
);

  sfr_pkg::cmd_t    cmd;
  sfr_pkg::status_t stat;

  sfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
